>>> rtl/core/zsbi_pkg.sv
// package with the item types and status codes of the zlib stored-block inflater
package zsbi_pkg;

   // adler-32 modulus and zlib header constants
   localparam logic [16:0] ADLER_MOD  = 17'd65521;
   localparam logic [3:0]  CM_DEFLATE = 4'd8;

   // status codes reported on the item that ends a stream
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_TOO_SMALL  = 4'd1;
   localparam logic [3:0] ST_METHOD     = 4'd2;
   localparam logic [3:0] ST_HDR_CHECK  = 4'd3;
   localparam logic [3:0] ST_DICT       = 4'd4;
   localparam logic [3:0] ST_END_BLKHDR = 4'd5;
   localparam logic [3:0] ST_BTYPE      = 4'd6;
   localparam logic [3:0] ST_TRUNC_LEN  = 4'd7;
   localparam logic [3:0] ST_LEN_CHECK  = 4'd8;
   localparam logic [3:0] ST_EXCEEDS    = 4'd9;
   localparam logic [3:0] ST_OUT_SMALL  = 4'd10;
   localparam logic [3:0] ST_ADLER      = 4'd11;

   // streams with fewer bytes than this are reported as too small
   localparam logic [2:0] MIN_STREAM_BYTES = 3'd6;

   // one stream byte
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       stream_end;
   } req_type;

   // one result item
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        status_valid;
      logic [3:0]  status_code;
      logic [31:0] bytes_written;
   } rsp_type;

endpackage

>>> rtl/core/zlib_stored_block_inflater_top.sv
// top level of the zlib stored-block inflater
//
// Takes a zlib stream one byte per item and passes out the payload of its stored
// deflate blocks, checking the zlib header, LEN/NLEN of each block and the
// big-endian Adler-32 trailer. One item is accepted per clock cycle while
// req_stall is low; the parse state, the two Adler-32 sums and the output count
// are updated in a single step between the input and the result register.
// An item yields a result when it carries a payload byte or ends the stream
// (stream_end); the end item also carries the status and, when the status is ok,
// the number of payload bytes. The first error is held until the end item. A
// two-entry result buffer keeps the input flowing while the result side stalls;
// req_stall rises only when both entries are full. csr_write_data sets the
// output capacity per stream; write it only while the block is idle (unchecked).
module zlib_stored_block_inflater_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  zsbi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output zsbi_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data
);
   import zsbi_pkg::*;

   typedef enum logic [2:0] {
      PH_CMF,
      PH_FLG,
      PH_BLKHDR,
      PH_LENS,
      PH_COPY,
      PH_TRAILER,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // configuration
   logic [31:0] capacity_ff;

   // stream state
   phase_type   phase_ff, phase_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  first_ff, first_in;
   logic        final_ff, final_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  inv_lo_ff, inv_lo_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] adler_lo_ff, adler_lo_in;
   logic [15:0] adler_hi_ff, adler_hi_in;
   logic [23:0] trailer_ff, trailer_in;
   logic [31:0] count_ff, count_in;
   logic [2:0]  count_sat_ff, count_sat_in;
   logic [3:0]  error_ff, error_in;

   // result buffer
   logic        out_valid_ff, skid_valid_ff;
   rsp_type     out_data_ff, skid_data_ff;

   logic        accept, pop, has_result, pay;
   logic [7:0]  b;
   rsp_type     result;
   logic [3:0]  code;

   // header check: 16-bit value mod 31 by folding 5-bit digits (32 = 1 mod 31)
   logic [15:0] hdr_word;
   logic [6:0]  fold1;
   logic [5:0]  fold2;
   logic        hdr_ok;

   // adler and capacity arithmetic
   logic [16:0] lo_sum, hi_sum;
   logic [15:0] lo_next;
   logic [32:0] cap_sum;
   logic        cap_over;

   assign b       = req_data.stream_byte;
   assign accept  = req_valid && !skid_valid_ff;
   assign pop     = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign hdr_word = {first_ff, b};
   assign fold1 = {2'b0, hdr_word[4:0]} + {2'b0, hdr_word[9:5]}
                + {2'b0, hdr_word[14:10]} + {6'b0, hdr_word[15]};
   assign fold2 = {1'b0, fold1[4:0]} + {4'b0, fold1[6:5]};
   assign hdr_ok = (fold2 == 6'd0) || (fold2 == 6'd31);

   // running sums stay below the modulus, so one subtract each
   assign lo_sum  = {1'b0, adler_lo_ff} + {9'b0, b};
   assign lo_next = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
   assign hi_sum  = {1'b0, adler_hi_ff} + {1'b0, lo_next};

   assign cap_sum  = {1'b0, count_ff} + {17'b0, len_ff};
   assign cap_over = cap_sum > {1'b0, capacity_ff};

   // parse step for one byte
   always_comb begin
      phase_in     = phase_ff;
      index_in     = index_ff;
      first_in     = first_ff;
      final_in     = final_ff;
      len_in       = len_ff;
      inv_lo_in    = inv_lo_ff;
      remain_in    = remain_ff;
      adler_lo_in  = adler_lo_ff;
      adler_hi_in  = adler_hi_ff;
      trailer_in   = trailer_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      count_sat_in = (count_sat_ff != 3'd7) ? count_sat_ff + 3'd1 : count_sat_ff;
      pay          = 1'b0;
      unique case (phase_ff)
         PH_CMF: begin
            first_in = b;
            phase_in = PH_FLG;
         end
         PH_FLG: begin
            if (first_ff[3:0] != CM_DEFLATE) begin
               error_in = ST_METHOD;
               phase_in = PH_ERROR;
            end else if (!hdr_ok) begin
               error_in = ST_HDR_CHECK;
               phase_in = PH_ERROR;
            end else if (b[5]) begin
               error_in = ST_DICT;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_BLKHDR;
            end
         end
         PH_BLKHDR: begin
            if (b[2:1] != 2'b00) begin
               error_in = ST_BTYPE;
               phase_in = PH_ERROR;
            end else begin
               final_in = b[0];
               phase_in = PH_LENS;
               index_in = 2'd0;
            end
         end
         PH_LENS: begin
            case (index_ff)
               2'd0:    len_in = {8'h00, b};
               2'd1:    len_in = {b, len_ff[7:0]};
               2'd2:    inv_lo_in = b;
               default: ;
            endcase
            if (index_ff != 2'd3) begin
               index_in = index_ff + 2'd1;
            end else if ((len_ff ^ 16'hFFFF) != {b, inv_lo_ff}) begin
               error_in = ST_LEN_CHECK;
               phase_in = PH_ERROR;
            end else if (cap_over) begin
               error_in = ST_OUT_SMALL;
               phase_in = PH_ERROR;
            end else if (len_ff == 16'd0) begin
               phase_in = final_ff ? PH_TRAILER : PH_BLKHDR;
               index_in = 2'd0;
            end else begin
               remain_in = len_ff;
               phase_in  = PH_COPY;
            end
         end
         PH_COPY: begin
            pay         = 1'b1;
            adler_lo_in = lo_next;
            adler_hi_in = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
            count_in    = count_ff + 32'd1;
            remain_in   = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               phase_in = final_ff ? PH_TRAILER : PH_BLKHDR;
               index_in = 2'd0;
            end
         end
         PH_TRAILER: begin
            trailer_in = {trailer_ff[15:0], b};
            if (index_ff != 2'd3) begin
               index_in = index_ff + 2'd1;
            end else if ({trailer_ff, b} != {adler_hi_ff, adler_lo_ff}) begin
               error_in = ST_ADLER;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE, PH_ERROR: ;
      endcase

      // status as seen after this byte
      if (count_sat_in < MIN_STREAM_BYTES) begin
         code = ST_TOO_SMALL;
      end else begin
         case (phase_in)
            PH_ERROR:  code = error_in;
            PH_DONE:   code = ST_OK;
            PH_BLKHDR: code = ST_END_BLKHDR;
            PH_LENS:   code = ST_TRUNC_LEN;
            PH_COPY:   code = ST_EXCEEDS;
            default:   code = ST_ADLER;
         endcase
      end

      result.payload_valid = pay;
      result.payload_byte  = pay ? b : 8'h00;
      result.status_valid  = req_data.stream_end;
      result.status_code   = req_data.stream_end ? code : ST_OK;
      result.bytes_written = (req_data.stream_end && code == ST_OK) ? count_in : 32'd0;
      has_result = accept && (pay || req_data.stream_end);

      // end of stream returns all stream state to its reset value
      if (req_data.stream_end) begin
         phase_in     = PH_CMF;
         index_in     = 2'd0;
         first_in     = 8'h00;
         final_in     = 1'b0;
         len_in       = 16'd0;
         inv_lo_in    = 8'h00;
         remain_in    = 16'd0;
         adler_lo_in  = 16'd1;
         adler_hi_in  = 16'd0;
         trailer_in   = 24'd0;
         count_in     = 32'd0;
         count_sat_in = 3'd0;
         error_in     = ST_OK;
      end
   end

   // stream state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 32'hFFFF_FFFF;
         phase_ff     <= PH_CMF;
         index_ff     <= 2'd0;
         first_ff     <= 8'h00;
         final_ff     <= 1'b0;
         len_ff       <= 16'd0;
         inv_lo_ff    <= 8'h00;
         remain_ff    <= 16'd0;
         adler_lo_ff  <= 16'd1;
         adler_hi_ff  <= 16'd0;
         trailer_ff   <= 24'd0;
         count_ff     <= 32'd0;
         count_sat_ff <= 3'd0;
         error_ff     <= ST_OK;
      end else begin
         if (csr_write_en) begin
            capacity_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            index_ff     <= index_in;
            first_ff     <= first_in;
            final_ff     <= final_in;
            len_ff       <= len_in;
            inv_lo_ff    <= inv_lo_in;
            remain_ff    <= remain_in;
            adler_lo_ff  <= adler_lo_in;
            adler_hi_ff  <= adler_hi_in;
            trailer_ff   <= trailer_in;
            count_ff     <= count_in;
            count_sat_ff <= count_sat_in;
            error_ff     <= error_in;
         end
      end
   end

   // result register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (has_result) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // skid entry is only used behind a full result register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while the result register is empty");

   // an end item leaves the parser ready for a new stream
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.stream_end) |=> (phase_ff == PH_CMF && count_ff == 32'd0))
      else $error("stream state not cleared after end item");

   // adler sums stay reduced
   assert property (@(posedge clock) disable iff (reset)
      (adler_lo_ff < ADLER_MOD[15:0]) && (adler_hi_ff < ADLER_MOD[15:0]))
      else $error("adler sum out of range");

   // copying always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COPY) |-> (remain_ff != 16'd0))
      else $error("copy phase with no bytes remaining");

   // failing status never reports a byte count
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status_code != ST_OK) |-> (out_data_ff.bytes_written == 32'd0))
      else $error("byte count reported with an error status");

endmodule
